FILE: design/cas_pkg.sv
// Shared types, sizes and arithmetic helpers for the circular angle smoother.
// Used by every module of the block; depends on nothing else.

package cas_pkg;

    localparam int MASK_TAPS     = 7;
    localparam int ANGLE_BITS    = 16;

    localparam int TAP_REGS      = 7;
    localparam int TAP_BITS      = 8;
    localparam int HALF_BITS     = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 8;
    localparam int HIST_DEPTH    = 7;
    localparam int HIST_IDX_BITS = 3;
    localparam int CNT_BITS      = 3;
    localparam int HALF_MAX      = (MASK_TAPS - 1) / 2;

    localparam int DIFF_BITS     = ANGLE_BITS + 1;
    localparam int OUT_BITS      = ANGLE_BITS + 1;
    localparam int TAP_IDX_BITS  = (MASK_TAPS > 1) ? $clog2(MASK_TAPS) : 1;
    localparam int TAP_CNT_BITS  = $clog2(MASK_TAPS + 1);
    localparam int WSUM_BITS     = TAP_BITS + $clog2(MASK_TAPS);
    localparam int SUM_BITS      = ANGLE_BITS + TAP_BITS + $clog2(MASK_TAPS);
    localparam int MAG_BITS      = SUM_BITS - 1;
    localparam int QUO_BITS      = ANGLE_BITS - 1;
    localparam int REM_BITS      = MAG_BITS - QUO_BITS;
    localparam int DIV_CNT_BITS  = $clog2(QUO_BITS);

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    // pi in Q2.(ANGLE_BITS-3), rounded from a Q29 value.
    localparam longint PI_Q29    = 64'sd1686629713;
    localparam int     FRAC_BITS = ANGLE_BITS - 3;
    localparam int     PI_SHIFT  = 29 - FRAC_BITS;
    localparam longint PI_FIX    = (PI_Q29 + (64'sd1 <<< (PI_SHIFT - 1))) >>> PI_SHIFT;

    localparam logic signed [DIFF_BITS-1:0] PI_D     = DIFF_BITS'(PI_FIX);
    localparam logic signed [DIFF_BITS-1:0] NEG_PI_D = DIFF_BITS'(-PI_FIX);
    localparam logic signed [DIFF_BITS-1:0] TWO_PI_D = DIFF_BITS'(2 * PI_FIX);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_0      = CFG_IDX_BITS'(1);

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic [TAP_REGS-1:0][TAP_BITS-1:0] tap_set_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle_in;
        logic                         last_in;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] angle_out;
        logic                       last_out;
    } result_t;

    // One smoothing request: the window already lined up by tap index.
    typedef struct packed {
        logic [MASK_TAPS-1:0]                 tap_en;
        logic [MASK_TAPS-1:0][ANGLE_BITS-1:0] win;
        angle_t                               centre;
        logic                                 last;
    } job_t;

    // A raw difference lies within two turns, so one correction is enough.
    function automatic angle_t wrap_diff(input logic signed [DIFF_BITS-1:0] raw);
        logic signed [DIFF_BITS-1:0] fixed;
        begin
            fixed = raw;
            if (raw > PI_D)
            begin
                fixed = raw - TWO_PI_D;
            end
            else if (raw < NEG_PI_D)
            begin
                fixed = raw + TWO_PI_D;
            end
            return fixed[ANGLE_BITS-1:0];
        end
    endfunction

endpackage

FILE: design/cas_job_queue.sv
// Short FIFO of smoothing requests between the front and the back end.
// Depends on cas_pkg for the request type and depth.

module cas_job_queue
    import cas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    job_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/cas_front.sv
// Front end: takes samples, keeps the angle history and sequence count, and
// turns each sample into zero or more smoothing requests. Depends on cas_pkg.

module cas_front
    import cas_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  sample_t              sample,
    input  logic [HALF_BITS-1:0] half_width,
    output logic                 job_push,
    output job_t                 job,
    input  logic                 q_full
);

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_ISSUE = 2'b10
    } front_state_t;

    front_state_t         state_reg;
    front_state_t         state_next;
    angle_t               hist_reg [HIST_DEPTH];
    angle_t               hist_next [HIST_DEPTH];
    logic [CNT_BITS-1:0]  seen_reg;
    logic [CNT_BITS-1:0]  seen_next;
    logic [CNT_BITS-1:0]  kcur_reg;
    logic [CNT_BITS-1:0]  kcur_next;
    logic [HALF_BITS-1:0] d_reg;
    logic [HALF_BITS-1:0] d_next;
    logic                 last_reg;
    logic                 last_next;
    logic [HALF_BITS-1:0] h_eff;

    assign h_eff = (half_width > HALF_BITS'(HALF_MAX)) ? HALF_BITS'(HALF_MAX) : half_width;

    assign sample_ready = (state_reg == F_IDLE);
    assign job_push     = (state_reg == F_ISSUE) && !q_full;

    // Control: accept a sample, then issue its requests one per cycle while the queue is not full.
    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        kcur_next  = kcur_reg;
        d_next     = d_reg;
        last_next  = last_reg;
        for (int n = 0; n < HIST_DEPTH; n++)
        begin
            hist_next[n] = hist_reg[n];
        end

        unique case (state_reg)
            F_IDLE:
            begin
                if (sample_valid)
                begin
                    for (int n = 1; n < HIST_DEPTH; n++)
                    begin
                        hist_next[n] = hist_reg[n-1];
                    end
                    hist_next[0] = sample.angle_in;
                    kcur_next    = seen_reg;
                    last_next    = sample.last_in;
                    if (sample.last_in)
                    begin
                        // Flush: positions from the oldest pending one down to the newest.
                        d_next     = (seen_reg < CNT_BITS'(h_eff)) ? seen_reg[HALF_BITS-1:0]
                                                                   : h_eff;
                        seen_next  = '0;
                        state_next = F_ISSUE;
                    end
                    else
                    begin
                        d_next    = h_eff;
                        seen_next = (seen_reg == CNT_BITS'(HIST_DEPTH)) ? seen_reg
                                                                        : seen_reg + 1'b1;
                        if (seen_reg >= CNT_BITS'(h_eff))
                        begin
                            state_next = F_ISSUE;
                        end
                    end
                end
            end
            F_ISSUE:
            begin
                if (!q_full)
                begin
                    if (last_reg && (d_reg != '0))
                    begin
                        d_next = d_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = F_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Request contents. Tap j sees the sample at history slot d+h-j; taps outside
    // the shrunken window are disabled and carry zero.
    always_comb
    begin
        logic [CNT_BITS-1:0]      pos;
        logic [CNT_BITS-1:0]      skip;
        logic [CNT_BITS-1:0]      alt;
        logic [CNT_BITS-1:0]      hi;
        logic [CNT_BITS-1:0]      dh;
        logic [CNT_BITS-1:0]      jv;
        logic [HIST_IDX_BITS-1:0] idx;
        logic                     en;

        pos  = kcur_reg - CNT_BITS'(d_reg);
        skip = (pos < CNT_BITS'(h_eff)) ? CNT_BITS'(h_eff) - pos : '0;
        alt  = CNT_BITS'(h_eff) - CNT_BITS'(d_reg);
        if (last_reg && (d_reg < h_eff) && (alt > skip))
        begin
            skip = alt;
        end
        hi = (CNT_BITS'(h_eff) << 1) - skip;
        dh = CNT_BITS'(d_reg) + CNT_BITS'(h_eff);

        for (int j = 0; j < MASK_TAPS; j++)
        begin
            jv  = CNT_BITS'(j);
            en  = (jv >= skip) && (jv <= hi) && (jv <= dh);
            idx = HIST_IDX_BITS'(dh - jv);
            job.tap_en[j] = en;
            job.win[j]    = en ? hist_reg[idx] : '0;
        end
        job.centre = hist_reg[HIST_IDX_BITS'(d_reg)];
        job.last   = last_reg && (d_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            seen_reg  <= '0;
            kcur_reg  <= '0;
            d_reg     <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            kcur_reg  <= kcur_next;
            d_reg     <= d_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < HIST_DEPTH; n++)
        begin
            hist_reg[n] <= hist_next[n];
        end
    end

endmodule

FILE: design/cas_back.sv
// Back end: weighted mean of wrapped differences with one multiply-accumulate
// per tap, an iterative restoring divider, and the result register. Uses cas_pkg.

module cas_back
    import cas_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tap_set_t taps,
    input  logic     q_empty,
    input  job_t     q_data,
    output logic     pop,
    output logic     result_valid,
    input  logic     result_ready,
    output result_t  result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } back_state_t;

    back_state_t                    state_reg;
    back_state_t                    state_next;
    logic [TAP_CNT_BITS-1:0]        tap_cnt_reg;
    logic [TAP_CNT_BITS-1:0]        tap_cnt_next;
    logic                           prod_vld_reg;
    logic                           prod_vld_next;
    logic [DIV_CNT_BITS-1:0]        div_cnt_reg;
    logic [DIV_CNT_BITS-1:0]        div_cnt_next;
    logic                           result_valid_reg;
    logic                           result_valid_next;

    job_t                           job_reg;
    job_t                           job_next;
    angle_t                         diff_reg;
    angle_t                         diff_next;
    logic [TAP_BITS-1:0]            w_reg;
    logic [TAP_BITS-1:0]            w_next;
    logic signed [SUM_BITS-1:0]     sum_reg;
    logic signed [SUM_BITS-1:0]     sum_next;
    logic [WSUM_BITS-1:0]           wsum_reg;
    logic [WSUM_BITS-1:0]           wsum_next;
    logic                           neg_reg;
    logic                           neg_next;
    logic [REM_BITS-1:0]            rem_reg;
    logic [REM_BITS-1:0]            rem_next;
    logic [QUO_BITS-1:0]            quo_reg;
    logic [QUO_BITS-1:0]            quo_next;
    result_t                        result_reg;
    result_t                        result_next;

    logic [TAP_IDX_BITS-1:0]        tap_sel;
    logic signed [ANGLE_BITS+TAP_BITS:0] product;

    assign tap_sel      = tap_cnt_reg[TAP_IDX_BITS-1:0];
    assign product      = diff_reg * $signed({1'b0, w_reg});
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        logic signed [DIFF_BITS-1:0] raw;
        logic signed [SUM_BITS-1:0]  abs_sum;
        logic [REM_BITS:0]           cand;
        logic signed [OUT_BITS-1:0]  mean;

        state_next        = state_reg;
        tap_cnt_next      = tap_cnt_reg;
        div_cnt_next      = div_cnt_reg;
        result_valid_next = result_valid_reg;
        job_next          = job_reg;
        diff_next         = diff_reg;
        w_next            = w_reg;
        sum_next          = sum_reg;
        wsum_next         = wsum_reg;
        neg_next          = neg_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        result_next       = result_reg;
        pop               = 1'b0;

        raw     = DIFF_BITS'($signed(job_reg.win[tap_sel])) - DIFF_BITS'(job_reg.centre);
        abs_sum = sum_reg[SUM_BITS-1] ? -sum_reg : sum_reg;
        cand    = {rem_reg, quo_reg[QUO_BITS-1]};
        mean    = neg_reg ? -OUT_BITS'(quo_reg) : OUT_BITS'(quo_reg);
        if (wsum_reg == '0)
        begin
            mean = '0;
        end

        prod_vld_next = (state_reg == S_MAC) && (tap_cnt_reg != TAP_CNT_BITS'(MASK_TAPS));

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop          = 1'b1;
                    job_next     = q_data;
                    tap_cnt_next = '0;
                    sum_next     = '0;
                    wsum_next    = '0;
                    state_next   = S_MAC;
                end
            end
            S_MAC:
            begin
                // Two-step pipe: wrap the difference, then multiply and accumulate.
                if (tap_cnt_reg != TAP_CNT_BITS'(MASK_TAPS))
                begin
                    diff_next    = wrap_diff(raw);
                    w_next       = job_reg.tap_en[tap_sel] ? taps[tap_sel] : '0;
                    tap_cnt_next = tap_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_PREP;
                end
                if (prod_vld_reg)
                begin
                    sum_next  = sum_reg + SUM_BITS'(product);
                    wsum_next = wsum_reg + WSUM_BITS'(w_reg);
                end
            end
            S_PREP:
            begin
                // The mean is bounded by pi, so only the low quotient bits can be set
                // and the top of the dividend already sits below the divisor.
                neg_next     = sum_reg[SUM_BITS-1];
                rem_next     = abs_sum[MAG_BITS-1:QUO_BITS];
                quo_next     = abs_sum[QUO_BITS-1:0];
                div_cnt_next = DIV_CNT_BITS'(QUO_BITS - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (cand >= {1'b0, wsum_reg})
                begin
                    rem_next = REM_BITS'(cand - {1'b0, wsum_reg});
                    quo_next = {quo_reg[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = cand[REM_BITS-1:0];
                    quo_next = {quo_reg[QUO_BITS-2:0], 1'b0};
                end
                if (div_cnt_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.angle_out = OUT_BITS'(job_reg.centre) + mean;
                    result_next.last_out  = job_reg.last;
                    result_valid_next     = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tap_cnt_reg      <= '0;
            prod_vld_reg     <= 1'b0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tap_cnt_reg      <= tap_cnt_next;
            prod_vld_reg     <= prod_vld_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        diff_reg   <= diff_next;
        w_reg      <= w_next;
        sum_reg    <= sum_next;
        wsum_reg   <= wsum_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        result_reg <= result_next;
    end

endmodule

FILE: design/circular_angle_smoother_unit.sv
// Top level of the circular angle smoother: configuration registers, front end,
// request queue and back end. Depends on cas_pkg, cas_front, cas_job_queue, cas_back.
//
// Usage:
//   sample (angle_in, last_in) enters on sample_valid/sample_ready; smoothed
//   angles leave on result_valid/result_ready as result (angle_out, last_out).
//   Registers are written on cfg_valid/cfg_ready: index 0 is the half width,
//   indexes 1 to 7 are the mask taps. cfg_ready is always high; write only
//   while no request is in flight.
//   A sample that completes a window makes one request; a sample marked last
//   makes one request per pending position, the final one flagged last_out.
//   The front end takes a sample, then queues its requests one per cycle
//   while the queue is not full. The back end takes one request at a time:
//   multiply-accumulate over the seven mask taps, then a fifteen-step
//   restoring divider; that divider sets the sustained rate.
//   When the receiver stalls, the finished result waits in the output
//   register, the back end works on the next queued request, and the front
//   end stops taking samples once the two-entry queue is full.
//   Reset empties the queue, clears the sequence count, sets the half width
//   to 3 and all taps to 1; the angle history holds no data until written.

module circular_angle_smoother_unit
    import cas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  sample_t                  sample,
    output logic                     result_valid,
    input  logic                     result_ready,
    output result_t                  result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [HALF_BITS-1:0] half_width_reg;
    logic [HALF_BITS-1:0] half_width_next;
    tap_set_t             taps_reg;
    tap_set_t             taps_next;

    logic job_push;
    job_t job_in;
    logic q_full;
    logic job_pop;
    job_t job_out;
    logic q_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        half_width_next = half_width_reg;
        taps_next       = taps_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_HALF_WIDTH)
            begin
                half_width_next = cfg_data[HALF_BITS-1:0];
            end
            else
            begin
                taps_next[cfg_index - REG_TAP_0] = cfg_data[TAP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= HALF_BITS'(3);
            for (int n = 0; n < TAP_REGS; n++)
            begin
                taps_reg[n] <= TAP_BITS'(1);
            end
        end
        else
        begin
            half_width_reg <= half_width_next;
            taps_reg       <= taps_next;
        end
    end

    cas_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .half_width   (half_width_reg),
        .job_push     (job_push),
        .job          (job_in),
        .q_full       (q_full)
    );

    cas_job_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (q_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (q_empty)
    );

    cas_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .taps         (taps_reg),
        .q_empty      (q_empty),
        .q_data       (job_out),
        .pop          (job_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    // The front end must never offer a request the queue cannot hold.
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !q_full)
        else $error("request pushed into a full queue");

    // The back end only takes a request that is there.
    assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> !q_empty)
        else $error("request popped from an empty queue");

    // After a sample is taken, the front end does not push a request into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !job_push || !q_full)
        else $error("front end issued a request against a full queue");
`endif

endmodule
